// File: rtl/fingerprint_hash_accumulator_assert.svh
// Assertion macros shared by the RTL.
`ifndef FINGERPRINT_HASH_ACCUMULATOR_ASSERT_SVH
`define FINGERPRINT_HASH_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FHACC_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define FHACC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: rtl/fhacc_pkg.sv
package fhacc_pkg;

	// Command codes
	localparam logic [2:0] CMD_START  = 3'd0;
	localparam logic [2:0] CMD_WORD   = 3'd1;
	localparam logic [2:0] CMD_BYTE   = 3'd2;
	localparam logic [2:0] CMD_STREND = 3'd3;
	localparam logic [2:0] CMD_EMIT   = 3'd4;

	// Hash constants
	localparam logic [63:0] GOLDEN_GAMMA = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [63:0] MIX_MUL_A    = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [63:0] MIX_MUL_B    = 64'h94d0_49bb_1331_11eb;
	localparam logic [63:0] FNV_BASIS    = 64'hcbf2_9ce4_8422_2325;
	localparam logic [63:0] FNV_PRIME    = 64'h0000_0100_0000_01b3;

	// Request to the shared multiplier
	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} mul_req_t;

	// Response from the shared multiplier
	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] product;
	} mul_rsp_t;

	// First part of the finalizer: add gamma, then xor-shift by 30
	function automatic logic [63:0] mix_pre(input logic [63:0] v);
		logic [63:0] z;
		z = v + GOLDEN_GAMMA;
		return z ^ (z >> 30);
	endfunction

endpackage

// File: rtl/fingerprint_hash_accumulator.sv
// Streaming 64-bit fingerprint accumulator. Start (0) loads the running
// hash with data_word; add word (1) folds data_word in through the
// splitmix64 finalizer; string byte (2) steps the FNV-1a 64 register with
// text_byte; string end (3) folds the FNV register in as a word and returns
// it to the offset basis; emit (4) sends the running hash as a fingerprint
// beat, zero shown as one; codes 5 to 7 do nothing. All 64-bit products go
// through one 32x32 multiplier, three partial products each, so the block
// takes one item at a time: start, emit and unused codes use no product,
// a string byte takes one product, and add word or string end take two
// dependent products. No item of any kind is taken while an earlier
// fingerprint beat is still waiting to be taken.
`include "fingerprint_hash_accumulator_assert.svh"

module fingerprint_hash_accumulator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [2:0]  command,
	input  logic [63:0] data_word,
	input  logic [7:0]  text_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [63:0] fingerprint
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MIX1 = 2'd1;
	localparam logic [1:0] ST_MIX2 = 2'd2;
	localparam logic [1:0] ST_FNV  = 2'd3;

	logic [1:0]  state_q;
	logic [1:0]  state_d;
	logic [63:0] hash_q;
	logic [63:0] str_q;
	logic        out_valid_q;
	logic [63:0] fp_q;
	logic        accept;

	// Terms used by the checks
	logic        emit_take;
	logic        quiet_take;
	logic        beat_ok;
	logic        mul_active;

	fhacc_pkg::mul_req_t mul_req;
	fhacc_pkg::mul_rsp_t mul_rsp;

	fhacc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	// Take an item when idle and the output beat has room
	assign item_ready = (state_q == ST_IDLE) && (!out_valid_q || result_ready);
	assign accept     = item_valid && item_ready;

	// Next state and multiplier requests
	always_comb begin
		state_d       = state_q;
		mul_req.start = 1'b0;
		mul_req.a     = fhacc_pkg::mix_pre(hash_q ^ data_word);
		mul_req.b     = fhacc_pkg::MIX_MUL_A;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						fhacc_pkg::CMD_WORD: begin
							mul_req.start = 1'b1;
							state_d       = ST_MIX1;
						end
						fhacc_pkg::CMD_STREND: begin
							mul_req.start = 1'b1;
							mul_req.a     = fhacc_pkg::mix_pre(hash_q ^ str_q);
							state_d       = ST_MIX1;
						end
						fhacc_pkg::CMD_BYTE: begin
							mul_req.start = 1'b1;
							mul_req.a     = str_q ^ {56'd0, text_byte};
							mul_req.b     = fhacc_pkg::FNV_PRIME;
							state_d       = ST_FNV;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_MIX1: begin
				// second xor-shift-multiply round
				mul_req.a = mul_rsp.product ^ (mul_rsp.product >> 27);
				mul_req.b = fhacc_pkg::MIX_MUL_B;
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					state_d       = ST_MIX2;
				end
			end
			ST_MIX2: begin
				if (mul_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			ST_FNV: begin
				if (mul_rsp.done) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer and hash state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hash_q  <= '0;
			str_q   <= fhacc_pkg::FNV_BASIS;
		end else begin
			state_q <= state_d;
			if (accept && command == fhacc_pkg::CMD_START) begin
				hash_q <= data_word;
			end
			if (accept && command == fhacc_pkg::CMD_STREND) begin
				str_q <= fhacc_pkg::FNV_BASIS;
			end
			if (state_q == ST_MIX2 && mul_rsp.done) begin
				hash_q <= mul_rsp.product ^ (mul_rsp.product >> 31);
			end
			if (state_q == ST_FNV && mul_rsp.done) begin
				str_q <= mul_rsp.product;
			end
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && command == fhacc_pkg::CMD_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && command == fhacc_pkg::CMD_EMIT) begin
			fp_q <= (hash_q == 64'd0) ? 64'd1 : hash_q;
		end
	end

	assign result_valid = out_valid_q;
	assign fingerprint  = fp_q;

	// Checks
	assign emit_take  = accept && (command == fhacc_pkg::CMD_EMIT);
	assign quiet_take = accept && (command != fhacc_pkg::CMD_EMIT) && !result_valid;
	assign beat_ok    = result_valid && (fingerprint != 64'd0);
	assign mul_active = mul_rsp.busy || mul_rsp.done;

	`FHACC_ASSERT_NEXT(a_emit_beat, clk, arst_n, emit_take, beat_ok, "no beat after emit")
	`FHACC_ASSERT_NEXT(a_no_stray, clk, arst_n, quiet_take, !result_valid, "beat without emit")
	`FHACC_ASSERT_NOW(a_mul_own, clk, arst_n, mul_active, state_q != ST_IDLE, "stray multiply")

endmodule

// File: rtl/fhacc_mul.sv
// Low 64 bits of a 64x64 product, built from three 32x32 partial
// products on one multiplier, one partial product per cycle.
module fhacc_mul (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fhacc_pkg::mul_req_t  req,
	output fhacc_pkg::mul_rsp_t  rsp
);

	localparam logic [1:0] STEP_LL = 2'd0;
	localparam logic [1:0] STEP_LH = 2'd1;
	localparam logic [1:0] STEP_HL = 2'd2;

	logic [1:0]  step_q;
	logic        busy_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;

	logic [31:0] op_a;
	logic [31:0] op_b;
	logic [63:0] part;

	// Operand select per step
	always_comb begin
		case (step_q)
			STEP_LL: begin
				op_a = a_q[31:0];
				op_b = b_q[31:0];
			end
			STEP_LH: begin
				op_a = a_q[31:0];
				op_b = b_q[63:32];
			end
			STEP_HL: begin
				op_a = a_q[63:32];
				op_b = b_q[31:0];
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// The shared 32x32 multiplier
	assign part = {32'd0, op_a} * {32'd0, op_b};

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_LL;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= STEP_LL;
			end else if (busy_q) begin
				if (step_q == STEP_HL) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + 2'd1;
				end
			end
		end
	end

	// Operands and accumulator
	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			if (step_q == STEP_LL) begin
				acc_q <= part;
			end else begin
				acc_q <= acc_q + {part[31:0], 32'd0};
			end
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = acc_q;

endmodule
